// File: design/hpe_pkg.sv
// Shared types, constants and helper functions for the hyperbolic positional encoder.
package hpe_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int LOGB_W    = 28;
   localparam int NUM_W     = 48;
   localparam int DIV_STG   = NUM_W;
   localparam int SPLIT_STG = 6;
   localparam int SA_STG    = 31;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 13'd64;
   localparam logic [LOGB_W-1:0] LOGB_RESET = 28'd154523870;

   // ln 2 in Q0.32 and other Q.32-scaled fixed-point constants
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [33:0] ONE_Q32   = 34'h1_0000_0000;
   localparam logic [37:0] BIG_LIMIT = 38'd187553801736;   // 63 * ln 2
   localparam logic [35:0] RAP_MAX   = 36'hF_0000_0000;     // 15.0

   typedef enum logic [1:0] {
      CSR_DIM  = 2'd0,
      CSR_LOGB = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [10:0]        pair_index;
      logic [19:0]        token_position;
      logic signed [31:0] even_element;
      logic signed [31:0] odd_element;
   } req_type;

   typedef struct packed {
      logic signed [63:0] boosted_even;
      logic signed [63:0] boosted_odd;
   } rsp_type;

   // data that rides along the arithmetic pipeline
   typedef struct packed {
      logic               trailing;
      logic signed [31:0] even;
      logic signed [31:0] odd;
      logic [19:0]        tpos;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DIM_W-1:0] dim;
      side_type         side;
   } qent_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
      logic       push;
   } fs_type;

   typedef struct packed {
      logic [DIM_W-1:0] rem;
      logic [NUM_W-1:0] quo;
      logic [NUM_W-1:0] num;
      logic [DIM_W-1:0] dim;
   } dv_type;

   typedef struct packed {
      logic        big;
      logic        zero;
      logic [5:0]  n;
      logic [37:0] rem;
   } spl_type;

   typedef struct packed {
      logic        big;
      logic        zero;
      logic [5:0]  n;
      logic [31:0] xu;
      logic [31:0] xd;
      logic [33:0] yu;
      logic [33:0] yd;
   } sa_type;

   typedef struct packed {
      logic        big;
      logic        zero;
      logic [5:0]  n;
      logic [33:0] yu;
      logic [33:0] yd;
   } eo_type;

   // long division, only used to build constants
   function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], a[i]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // ln(1 + 2^-i) in Q0.32 from its alternating series in Q.62
   function automatic logic [31:0] ln_rom(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      acc = '0;
      for (int j = 1; j < 62; j++) begin
         if (i * j < 62) begin
            term = cdiv(64'd1 << (62 - i * j), 64'(j));
            if (j[0]) acc = acc + term;
            else      acc = acc - term;
         end
      end
      return 32'((acc + (64'd1 << 29)) >> 30);
   endfunction

   // one quotient bit of the restoring divider
   function automatic dv_type div_step(input dv_type s);
      dv_type      o;
      logic [13:0] t;
      o     = s;
      t     = {s.rem, s.num[NUM_W-1]};
      o.num = {s.num[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, s.dim}) begin
         o.rem = 13'(t - {1'b0, s.dim});
         o.quo = {s.quo[NUM_W-2:0], 1'b1};
      end else begin
         o.rem = t[12:0];
         o.quo = {s.quo[NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // one bit of n = floor(v / ln2)
   function automatic spl_type split_step(input spl_type s, input logic [37:0] lim,
                                          input logic [5:0] mask);
      spl_type o;
      o = s;
      if (s.rem >= lim) begin
         o.rem = s.rem - lim;
         o.n   = s.n | mask;
      end
      return o;
   endfunction

   // one shift-and-add step of exp on both arguments
   function automatic sa_type sa_step(input sa_type s, input logic [31:0] k, input int sh);
      sa_type o;
      o = s;
      if (s.xu >= k) begin
         o.xu = s.xu - k;
         o.yu = s.yu + (s.yu >> sh);
      end
      if (s.xd >= k) begin
         o.xd = s.xd - k;
         o.yd = s.yd + (s.yd >> sh);
      end
      return o;
   endfunction

endpackage

// File: design/hyperbolic_positional_encode.sv
// Top level of the hyperbolic positional encoder: front end, back end and checks.
//
// Usage:
//   A request (pair index, token position, even and odd Q16.16 elements) is taken at a
//   rising edge where start is high and busy is low. One result (boosted even and odd
//   elements, Q48.16) appears on rsp_data for exactly one cycle with rsp_valid high,
//   after the queue, divider, exponential units and back-end stages, in request order.
//   Throughput is one request per cycle: the divider, both exponential units and the
//   multiply stages are fully pipelined, one quotient bit or one shift-and-add step
//   per stage, so every stage takes a new request each cycle.
//   The receiver cannot stall the block; results are presented once and never held.
//   busy comes from the two-entry queue between the front and back ends; since the
//   back end drains it every cycle it stays low in operation.
//   csr_we writes vector_dimension (index 0) or log_base (index 1) in the same edge;
//   other indexes are ignored. Write only while no request is in flight.
//   Synchronous reset clears all valid bits, empties the queue and restores
//   vector_dimension = 64 and log_base = ln 10000; no clearing pass is needed.
module hyperbolic_positional_encode (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hpe_pkg::req_type req_data,
   output logic             rsp_valid,
   output hpe_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [27:0]      csr_wdata
);
   import hpe_pkg::*;

   logic     q_valid;
   qent_type q_head;
   logic     q_pop;
   fs_type   fsts;

   hpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .sts       (fsts)
   );

   hpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_entry  (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // the back end drains the queue every cycle, so it never holds more than one entry
   a_queue_drained: assert property (@(posedge clock) disable iff (reset)
      fsts.count == 2'd0 || fsts.count == 2'd1)
      else $error("front queue backed up");

   // a queued request is popped in the cycle after it was pushed
   a_pop_follows_push: assert property (@(posedge clock) disable iff (reset)
      fsts.push |=> q_valid && q_pop)
      else $error("queued request not taken by back end");

   // busy never blocks a request while the pipeline runs
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

// File: design/hpe_front.sv
// Front end: request capture, register file, classification and the hand-off queue.
module hpe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hpe_pkg::req_type  req_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [27:0]       csr_wdata,
   input  logic              pop,
   output logic              q_valid,
   output hpe_pkg::qent_type q_head,
   output hpe_pkg::fs_type   sts
);
   import hpe_pkg::*;

   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [LOGB_W-1:0] logb_ff, logb_in;
   logic              fr_v_ff;
   req_type           fr_ff;
   logic [DIM_W-1:0]  frdim_ff, frdim_in;
   qent_type          ent_ff [0:1];
   qent_type          new_ent;
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              accept, push, do_pop;
   logic [39:0]       prod;

   // register writes
   always_comb begin
      dim_in  = dim_ff;
      logb_in = logb_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_DIM:  dim_in  = csr_wdata[DIM_W-1:0];
            CSR_LOGB: logb_in = csr_wdata[LOGB_W-1:0];
            default:  ;
         endcase
      end
   end

   // dimension clamped to the legal range
   always_comb begin
      if (dim_ff < 13'd2)
         frdim_in = 13'd2;
      else if (dim_ff > 13'(MAX_DIM))
         frdim_in = 13'(MAX_DIM);
      else
         frdim_in = dim_ff;
   end

   assign busy   = (cnt_ff == 2'd2);
   assign accept = start && !busy;

   // classify and form the exponent numerator 2k * ln(base) << 8
   always_comb begin
      prod                = {28'b0, fr_ff.pair_index, 1'b0} * {12'b0, logb_ff};
      new_ent.num         = {prod, 8'b0};
      new_ent.dim         = frdim_ff;
      new_ent.side.trailing = frdim_ff[0] && (12'(fr_ff.pair_index) == frdim_ff[12:1]);
      new_ent.side.even   = fr_ff.even_element;
      new_ent.side.odd    = fr_ff.odd_element;
      new_ent.side.tpos   = fr_ff.token_position;
   end

   assign push    = fr_v_ff;
   assign q_valid = (cnt_ff != 2'd0);
   assign do_pop  = pop && q_valid;
   assign q_head  = ent_ff[rp_ff];
   assign cnt_in  = cnt_ff + {1'b0, push} - {1'b0, do_pop};

   assign sts.count = cnt_ff;
   assign sts.full  = busy;
   assign sts.push  = push;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= DIM_RESET;
         logb_ff <= LOGB_RESET;
         fr_v_ff <= 1'b0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         dim_ff  <= dim_in;
         logb_ff <= logb_in;
         fr_v_ff <= accept;
         cnt_ff  <= cnt_in;
         if (push)   wp_ff <= ~wp_ff;
         if (do_pop) rp_ff <= ~rp_ff;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         fr_ff    <= req_data;
         frdim_ff <= frdim_in;
      end
      if (push)
         ent_ff[wp_ff] <= new_ent;
   end

endmodule

// File: design/hpe_div.sv
// Pipelined restoring divider: one quotient bit per stage for the exponent 2k*ln(base)*256/D.
module hpe_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [hpe_pkg::NUM_W-1:0] in_num,
   input  logic [hpe_pkg::DIM_W-1:0] in_dim,
   input  hpe_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [hpe_pkg::NUM_W-1:0] out_quo,
   output hpe_pkg::side_type         out_side
);
   import hpe_pkg::*;

   dv_type   src    [0:DIV_STG-1];
   dv_type   st_in  [0:DIV_STG-1];
   dv_type   st_ff  [0:DIV_STG-1];
   logic     v_src  [0:DIV_STG-1];
   logic     v_ff   [0:DIV_STG-1];
   side_type sd_src [0:DIV_STG-1];
   side_type sd_ff  [0:DIV_STG-1];

   for (genvar s = 0; s < DIV_STG; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src[s]    = '{rem: '0, quo: '0, num: in_num, dim: in_dim};
         assign v_src[s]  = in_valid;
         assign sd_src[s] = in_side;
      end else begin : g_rest
         assign src[s]    = st_ff[s-1];
         assign v_src[s]  = v_ff[s-1];
         assign sd_src[s] = sd_ff[s-1];
      end
      assign st_in[s] = div_step(src[s]);

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else        v_ff[s] <= v_src[s];
      end
      always_ff @(posedge clock) begin
         st_ff[s] <= st_in[s];
         sd_ff[s] <= sd_src[s];
      end
   end

   assign out_valid = v_ff[DIV_STG-1];
   assign out_quo   = st_ff[DIV_STG-1].quo;
   assign out_side  = sd_ff[DIV_STG-1];

endmodule

// File: design/hpe_exp.sv
// Pipelined exponential: split v = n*ln2 + f, then shift-and-add exp(f) and exp(ln2 - f).
module hpe_exp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [hpe_pkg::NUM_W-1:0] in_value,
   input  hpe_pkg::side_type         in_side,
   output logic                      out_valid,
   output hpe_pkg::eo_type           out_res,
   output hpe_pkg::side_type         out_side
);
   import hpe_pkg::*;

   // range check stage
   spl_type  rs_ff, rs_in;
   logic     rv_ff;
   side_type rsd_ff;

   spl_type  sp_src [0:SPLIT_STG-1];
   spl_type  sp_in  [0:SPLIT_STG-1];
   spl_type  sp_ff  [0:SPLIT_STG-1];
   logic     spv_src [0:SPLIT_STG-1];
   logic     spv_ff  [0:SPLIT_STG-1];
   side_type spd_src [0:SPLIT_STG-1];
   side_type spd_ff  [0:SPLIT_STG-1];

   sa_type   sa_src [0:SA_STG-1];
   sa_type   sa_in  [0:SA_STG-1];
   sa_type   sa_ff  [0:SA_STG-1];
   logic     sav_src [0:SA_STG-1];
   logic     sav_ff  [0:SA_STG-1];
   side_type sad_src [0:SA_STG-1];
   side_type sad_ff  [0:SA_STG-1];

   always_comb begin
      rs_in.big  = (in_value >= NUM_W'(BIG_LIMIT));
      rs_in.zero = (in_value == '0);
      rs_in.n    = '0;
      rs_in.rem  = rs_in.big ? '0 : in_value[37:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      rs_ff  <= rs_in;
      rsd_ff <= in_side;
   end

   // quotient bits of v / ln2, high bit first
   for (genvar k = 0; k < SPLIT_STG; k++) begin : g_split
      localparam logic [37:0] LIM  = 38'(LN2_Q32) << (SPLIT_STG - 1 - k);
      localparam logic [5:0]  MASK = 6'd1 << (SPLIT_STG - 1 - k);
      if (k == 0) begin : g_first
         assign sp_src[k]  = rs_ff;
         assign spv_src[k] = rv_ff;
         assign spd_src[k] = rsd_ff;
      end else begin : g_rest
         assign sp_src[k]  = sp_ff[k-1];
         assign spv_src[k] = spv_ff[k-1];
         assign spd_src[k] = spd_ff[k-1];
      end
      assign sp_in[k] = split_step(sp_src[k], LIM, MASK);

      always_ff @(posedge clock) begin
         if (reset) spv_ff[k] <= 1'b0;
         else       spv_ff[k] <= spv_src[k];
      end
      always_ff @(posedge clock) begin
         sp_ff[k]  <= sp_in[k];
         spd_ff[k] <= spd_src[k];
      end
   end

   // shift-and-add steps, ROM entry i+1 in stage i
   for (genvar i = 0; i < SA_STG; i++) begin : g_sa
      localparam logic [31:0] KROM = ln_rom(i + 1);
      if (i == 0) begin : g_first
         assign sa_src[i].big  = sp_ff[SPLIT_STG-1].big;
         assign sa_src[i].zero = sp_ff[SPLIT_STG-1].zero;
         assign sa_src[i].n    = sp_ff[SPLIT_STG-1].n;
         assign sa_src[i].xu   = sp_ff[SPLIT_STG-1].rem[31:0];
         assign sa_src[i].xd   = LN2_Q32 - sp_ff[SPLIT_STG-1].rem[31:0];
         assign sa_src[i].yu   = ONE_Q32;
         assign sa_src[i].yd   = ONE_Q32;
         assign sav_src[i]     = spv_ff[SPLIT_STG-1];
         assign sad_src[i]     = spd_ff[SPLIT_STG-1];
      end else begin : g_rest
         assign sa_src[i]  = sa_ff[i-1];
         assign sav_src[i] = sav_ff[i-1];
         assign sad_src[i] = sad_ff[i-1];
      end
      assign sa_in[i] = sa_step(sa_src[i], KROM, i + 1);

      always_ff @(posedge clock) begin
         if (reset) sav_ff[i] <= 1'b0;
         else       sav_ff[i] <= sav_src[i];
      end
      always_ff @(posedge clock) begin
         sa_ff[i]  <= sa_in[i];
         sad_ff[i] <= sad_src[i];
      end
   end

   assign out_valid    = sav_ff[SA_STG-1];
   assign out_res.big  = sa_ff[SA_STG-1].big;
   assign out_res.zero = sa_ff[SA_STG-1].zero;
   assign out_res.n    = sa_ff[SA_STG-1].n;
   assign out_res.yu   = sa_ff[SA_STG-1].yu;
   assign out_res.yd   = sa_ff[SA_STG-1].yd;
   assign out_side     = sad_ff[SA_STG-1];

endmodule

// File: design/hpe_back.sv
// Back end: exponent divide, frequency, rapidity, cosh/sinh and the boost products.
module hpe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hpe_pkg::qent_type in_entry,
   output logic              pop,
   output logic              rsp_valid,
   output hpe_pkg::rsp_type  rsp_data
);
   import hpe_pkg::*;

   logic             dv_v;
   logic [NUM_W-1:0] dv_quo;
   side_type         dv_sd;

   logic             e1_v;
   eo_type           e1_r;
   side_type         e1_sd;

   logic             fq_v_ff;
   logic [32:0]      fq_ff, fq_in;
   side_type         fq_sd_ff;

   logic             rp_v_ff;
   logic [52:0]      rp_ff;
   side_type         rp_sd_ff;

   logic             rc_v_ff;
   logic [35:0]      rc_ff, rc_in;
   side_type         rc_sd_ff;

   logic             e2_v;
   eo_type           e2_r;
   side_type         e2_sd;

   logic             ex_v_ff;
   logic [55:0]      ep_ff, ep_in, em_ff, em_in;
   side_type         ex_sd_ff;

   logic             hc_v_ff;
   logic [55:0]      cz_ff, cz_in, sz_ff, sz_in;
   logic [31:0]      me_ff, me_in, mo_ff, mo_in;
   side_type         hc_sd_ff;

   logic             pr_v_ff;
   logic [55:0]      ec_hi_ff, es_hi_ff, oc_hi_ff, os_hi_ff;
   logic [63:0]      ec_lo_ff, es_lo_ff, oc_lo_ff, os_lo_ff;
   side_type         pr_sd_ff;

   logic             sm_v_ff;
   logic signed [63:0] ec_ff, es_ff, oc_ff, os_ff, ec_in, es_in, oc_in, os_in;
   side_type         sm_sd_ff;

   logic             out_v_ff;
   rsp_type          out_ff, out_in;

   // the back end never stalls, so it drains the queue every cycle
   assign pop = in_valid;

   hpe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    (in_entry.num),
      .in_dim    (in_entry.dim),
      .in_side   (in_entry.side),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_side  (dv_sd)
   );

   hpe_exp u_exp_freq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_v),
      .in_value  (dv_quo),
      .in_side   (dv_sd),
      .out_valid (e1_v),
      .out_res   (e1_r),
      .out_side  (e1_sd)
   );

   // frequency w = exp(-e)
   always_comb begin
      if (e1_r.zero)
         fq_in = 33'(ONE_Q32);
      else if (e1_r.big)
         fq_in = '0;
      else
         fq_in = 33'(e1_r.yd >> ({1'b0, e1_r.n} + 7'd1));
   end

   // rapidity clamp
   assign rc_in = (rp_ff > 53'(RAP_MAX)) ? RAP_MAX : rp_ff[35:0];

   hpe_exp u_exp_rap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rc_v_ff),
      .in_value  (NUM_W'(rc_ff)),
      .in_side   (rc_sd_ff),
      .out_valid (e2_v),
      .out_res   (e2_r),
      .out_side  (e2_sd)
   );

   // exp(+r) and exp(-r)
   assign ep_in = 56'(e2_r.yu) << e2_r.n;
   assign em_in = e2_r.zero ? 56'(ONE_Q32) : 56'(e2_r.yd >> ({1'b0, e2_r.n} + 7'd1));

   // cosh, sinh and element magnitudes
   always_comb begin
      cz_in = 56'((57'(ep_ff) + 57'(em_ff)) >> 1);
      sz_in = (ep_ff >= em_ff) ? ((ep_ff - em_ff) >> 1) : '0;
      me_in = ex_sd_ff.even[31] ? 32'(32'd0 - ex_sd_ff.even) : ex_sd_ff.even;
      mo_in = ex_sd_ff.odd[31]  ? 32'(32'd0 - ex_sd_ff.odd)  : ex_sd_ff.odd;
   end

   // combine partial products, truncate toward zero, restore sign
   always_comb begin
      logic [63:0] ec_m, es_m, oc_m, os_m;
      ec_m  = 64'(ec_hi_ff) + (ec_lo_ff >> 32);
      es_m  = 64'(es_hi_ff) + (es_lo_ff >> 32);
      oc_m  = 64'(oc_hi_ff) + (oc_lo_ff >> 32);
      os_m  = 64'(os_hi_ff) + (os_lo_ff >> 32);
      ec_in = pr_sd_ff.even[31] ? -$signed(ec_m) : $signed(ec_m);
      es_in = pr_sd_ff.even[31] ? -$signed(es_m) : $signed(es_m);
      oc_in = pr_sd_ff.odd[31]  ? -$signed(oc_m) : $signed(oc_m);
      os_in = pr_sd_ff.odd[31]  ? -$signed(os_m) : $signed(os_m);
   end

   // boost sums, or pass-through for the trailing lone element
   always_comb begin
      if (sm_sd_ff.trailing) begin
         out_in.boosted_even = 64'(sm_sd_ff.even);
         out_in.boosted_odd  = '0;
      end else begin
         out_in.boosted_even = ec_ff + os_ff;
         out_in.boosted_odd  = oc_ff + es_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fq_v_ff  <= 1'b0;
         rp_v_ff  <= 1'b0;
         rc_v_ff  <= 1'b0;
         ex_v_ff  <= 1'b0;
         hc_v_ff  <= 1'b0;
         pr_v_ff  <= 1'b0;
         sm_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         fq_v_ff  <= e1_v;
         rp_v_ff  <= fq_v_ff;
         rc_v_ff  <= rp_v_ff;
         ex_v_ff  <= e2_v;
         hc_v_ff  <= ex_v_ff;
         pr_v_ff  <= hc_v_ff;
         sm_v_ff  <= pr_v_ff;
         out_v_ff <= sm_v_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      fq_ff    <= fq_in;
      fq_sd_ff <= e1_sd;
      rp_ff    <= fq_ff * fq_sd_ff.tpos;
      rp_sd_ff <= fq_sd_ff;
      rc_ff    <= rc_in;
      rc_sd_ff <= rp_sd_ff;
      ep_ff    <= ep_in;
      em_ff    <= em_in;
      ex_sd_ff <= e2_sd;
      cz_ff    <= cz_in;
      sz_ff    <= sz_in;
      me_ff    <= me_in;
      mo_ff    <= mo_in;
      hc_sd_ff <= ex_sd_ff;
      ec_hi_ff <= me_ff * cz_ff[55:32];
      ec_lo_ff <= me_ff * cz_ff[31:0];
      es_hi_ff <= me_ff * sz_ff[55:32];
      es_lo_ff <= me_ff * sz_ff[31:0];
      oc_hi_ff <= mo_ff * cz_ff[55:32];
      oc_lo_ff <= mo_ff * cz_ff[31:0];
      os_hi_ff <= mo_ff * sz_ff[55:32];
      os_lo_ff <= mo_ff * sz_ff[31:0];
      pr_sd_ff <= hc_sd_ff;
      ec_ff    <= ec_in;
      es_ff    <= es_in;
      oc_ff    <= oc_in;
      os_ff    <= os_in;
      sm_sd_ff <= pr_sd_ff;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule
